// ===== sv/length_prefixed_chunk_parser_core_assert.svh =====
// Assertion macros shared by the chunk parser RTL.
`ifndef LENGTH_PREFIXED_CHUNK_PARSER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_CHUNK_PARSER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define LPCP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpcp assertion failed");
// Next-cycle implication, checked outside reset.
`define LPCP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpcp assertion failed");
`else
`define LPCP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPCP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/lpcp_pkg.sv =====
// Types, constants and parser state layout for the chunk parser.
package lpcp_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int CFG_BITS    = 16;
   // wide enough for accum*10+digit and for the configured maximum
   localparam int CMP_BITS    = (LENGTH_BITS + 4 > CFG_BITS) ? LENGTH_BITS + 4 : CFG_BITS;

   localparam logic [7:0] OPEN_CHAR  = 8'h28;
   localparam logic [7:0] CLOSE_CHAR = 8'h29;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam logic ACT_CLEAR = 1'b1;

   typedef logic [LENGTH_BITS-1:0] len_type;
   typedef logic [CFG_BITS-1:0]    cfg_type;
   typedef logic [CMP_BITS-1:0]    cmp_type;

   localparam cfg_type MAX_LEN_RESET = '1;

   typedef enum logic [1:0] {
      PH_OPEN = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OPEN      = 2'd0,
      ERR_DIGIT     = 2'd1,
      ERR_TOO_LARGE = 2'd2,
      ERR_EMPTY     = 2'd3
   } err_type;

   typedef struct packed {
      phase_type phase;
      len_type   length_accum;
      logic      digits_seen;
      len_type   bytes_left;
      logic      payload_turn;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       last_of_chunk;
      logic       is_payload;
      err_type    error_code;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_OPEN,
      length_accum: '0,
      digits_seen:  1'b0,
      bytes_left:   '0,
      payload_turn: 1'b0
   };

endpackage

// ===== sv/lpcp_channels.sv =====
// Handshake channel interfaces for the chunk parser: input, result and register write.
interface lpcp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_byte;
   modport source (output valid, action, in_byte, input ready);
   modport sink   (input valid, action, in_byte, output ready);
endinterface

interface lpcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last_of_chunk;
   logic       is_payload;
   logic [1:0] error_code;
   modport source (output valid, kind, out_byte, last_of_chunk, is_payload, error_code,
                   input ready);
   modport sink   (input valid, kind, out_byte, last_of_chunk, is_payload, error_code,
                   output ready);
endinterface

interface lpcp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_chunk_length;
   modport source (output valid, max_chunk_length, input ready);
   modport sink   (input valid, max_chunk_length, output ready);
endinterface

// ===== sv/lpcp_step.sv =====
// Next-state and result logic of the parser for one input item.
module lpcp_step (
   input  lpcp_pkg::state_type  st,
   input  logic                 action,
   input  logic [7:0]           in_byte,
   input  lpcp_pkg::cfg_type    max_len,
   output lpcp_pkg::state_type  st_next,
   output logic                 res_valid,
   output lpcp_pkg::result_type res
);
   import lpcp_pkg::*;

   cmp_type cap;
   cmp_type max_ext;
   cmp_type limit;
   cmp_type accum_ext;
   cmp_type next_len;
   len_type left_dec;
   logic    is_digit;

   assign cap       = CMP_BITS'({LENGTH_BITS{1'b1}});
   assign max_ext   = CMP_BITS'(max_len);
   assign limit     = (max_ext < cap) ? max_ext : cap;
   assign accum_ext = CMP_BITS'(st.length_accum);
   // times ten as two shifts and an add
   assign next_len  = (accum_ext << 3) + (accum_ext << 1) + CMP_BITS'(in_byte[3:0]);
   assign is_digit  = (in_byte >= DIGIT_ZERO) && (in_byte <= DIGIT_NINE);
   assign left_dec  = (st.bytes_left != '0) ? st.bytes_left - len_type'(1) : st.bytes_left;

   always_comb begin
      st_next   = st;
      res_valid = 1'b0;
      res       = '0;
      if (action == ACT_CLEAR) begin
         st_next = STATE_RESET;
      end else begin
         case (st.phase)
            PH_LEN: begin
               if (in_byte == CLOSE_CHAR) begin
                  if (!st.digits_seen) begin
                     st_next        = STATE_RESET;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_EMPTY;
                  end else if (st.length_accum == '0) begin
                     // empty chunk: marker now, straight back to '('
                     st_next.phase        = PH_OPEN;
                     st_next.digits_seen  = 1'b0;
                     st_next.payload_turn = ~st.payload_turn;
                     res_valid            = 1'b1;
                     res.kind             = KIND_EMPTY;
                     res.last_of_chunk    = 1'b1;
                     res.is_payload       = st.payload_turn;
                  end else begin
                     st_next.bytes_left   = st.length_accum;
                     st_next.length_accum = '0;
                     st_next.digits_seen  = 1'b0;
                     st_next.phase        = PH_DATA;
                  end
               end else if (!is_digit) begin
                  st_next        = STATE_RESET;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_DIGIT;
               end else if (next_len > limit) begin
                  st_next        = STATE_RESET;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_TOO_LARGE;
               end else begin
                  st_next.length_accum = next_len[LENGTH_BITS-1:0];
                  st_next.digits_seen  = 1'b1;
               end
            end
            PH_DATA: begin
               st_next.bytes_left = left_dec;
               if (left_dec == '0) begin
                  st_next.phase        = PH_OPEN;
                  st_next.payload_turn = ~st.payload_turn;
               end
               res_valid         = 1'b1;
               res.kind          = KIND_BYTE;
               res.out_byte      = in_byte;
               res.last_of_chunk = (left_dec == '0);
               res.is_payload    = st.payload_turn;
            end
            default: begin
               if (in_byte != OPEN_CHAR) begin
                  st_next        = STATE_RESET;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_OPEN;
               end else begin
                  st_next.phase        = PH_LEN;
                  st_next.length_accum = '0;
                  st_next.digits_seen  = 1'b0;
               end
            end
         endcase
      end
   end

endmodule

// ===== sv/length_prefixed_chunk_parser_core.sv =====
// Length-prefixed chunk parser: top level with parser state and result buffer.
// Usage:
//  req: one stream byte per item (action feed) or a clear (action clear).
//  rsp: at most one result per item: a chunk byte with its last mark, an
//       empty-chunk marker, or a framing error (parser then back to idle).
//  csr: writes max_chunk_length; always ready, write only while idle.
// Each result is registered in the output register or the skid entry before rsp shows it.
// Throughput: one item per cycle while req.ready is high; parser state updates
//  in the cycle the item is taken, so consecutive bytes never wait on each other.
// A two-deep result buffer (output register plus skid entry) parts the
//  channels: req.ready depends only on the skid entry, so when rsp stalls
//  one more item with a result is still taken (items without a result keep
//  flowing) and then req.ready drops until rsp takes one result.
// Reset: parser returns to expecting '(', name chunk next, buffer empty,
//  max_chunk_length back to 65535.
module length_prefixed_chunk_parser_core (
   input logic        clock,
   input logic        reset,
   lpcp_req_if.sink   req,
   lpcp_rsp_if.source rsp,
   lpcp_csr_if.sink   csr
);
   import lpcp_pkg::*;
   `include "length_prefixed_chunk_parser_core_assert.svh"

   state_type  state_ff, state_in;
   cfg_type    max_len_ff, max_len_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   state_type  st_next;
   logic       res_valid;
   result_type res;
   logic       accept;
   logic       produce;
   logic       drain;

   lpcp_step u_step (
      .st        (state_ff),
      .action    (req.action),
      .in_byte   (req.in_byte),
      .max_len   (max_len_ff),
      .st_next   (st_next),
      .res_valid (res_valid),
      .res       (res)
   );

   assign req.ready = ~skid_valid_ff;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign produce   = accept && res_valid;
   assign drain     = out_valid_ff && rsp.ready;

   always_comb begin
      state_in      = accept ? st_next : state_ff;
      max_len_in    = (csr.valid && csr.ready) ? cfg_type'(csr.max_chunk_length) : max_len_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (produce) begin
            out_in = res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (out_valid_ff) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         max_len_ff    <= MAX_LEN_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_len_ff    <= max_len_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.kind          = 2'(out_ff.kind);
   assign rsp.out_byte      = out_ff.out_byte;
   assign rsp.last_of_chunk = out_ff.last_of_chunk;
   assign rsp.is_payload    = out_ff.is_payload;
   assign rsp.error_code    = 2'(out_ff.error_code);

   // skid entry is only ever filled behind a held output register
   `LPCP_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // a data phase always has at least one byte to come
   `LPCP_ASSERT_IMP(a_data_has_bytes, clock, reset, state_ff.phase == PH_DATA,
                    state_ff.bytes_left != '0)
   // idle parser carries no leftover length
   `LPCP_ASSERT_IMP(a_open_is_clean, clock, reset, state_ff.phase == PH_OPEN,
                    state_ff.length_accum == '0 && !state_ff.digits_seen &&
                    state_ff.bytes_left == '0)
   // an item with a result never finds both buffer entries taken
   `LPCP_ASSERT_NXT(a_result_lands, clock, reset, produce && !drain && out_valid_ff,
                    skid_valid_ff)

endmodule
